// ===== hw/rtl/bqc_pkg.sv =====
package bqc_pkg;

    localparam int STAGES     = 4;
    localparam int SLOTS      = 5;
    localparam int STAGE_W    = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int CNT_W      = $clog2(STAGES + 1);
    localparam int DATA_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int COEF_SHIFT = 14;
    localparam int SHR_W      = ACC_W - COEF_SHIFT;

    localparam logic [2:0] ACTIVE_RESET = 3'd4;

    localparam logic [2:0] SLOT_B0 = 3'd0;
    localparam logic [2:0] SLOT_B1 = 3'd1;
    localparam logic [2:0] SLOT_B2 = 3'd2;
    localparam logic [2:0] SLOT_A1 = 3'd3;
    localparam logic [2:0] SLOT_A2 = 3'd4;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sd32767;
    localparam logic signed [DATA_W-1:0] SAT_MIN = -16'sd32768;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic acc_en;
        logic sub;
    } t_mac_ctl;

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SHR_W-1:0] v);
        logic signed [SHR_W-1:0] hi;
        logic signed [SHR_W-1:0] lo;
        hi = SHR_W'(SAT_MAX);
        lo = SHR_W'(SAT_MIN);
        if (v > hi) begin
            return SAT_MAX;
        end else if (v < lo) begin
            return SAT_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/biquad_cascade_q14_top.sv =====
// channel   direction  handshake          payload
// input     in         i_valid / o_ready  i_req_type i_sample_in i_coef_stage i_coef_slot
//                                         i_coef_value
// output    out        o_valid / i_ready  o_filt_out
// config    in         i_cfg_we           i_cfg_wdata (active_stages)
//
// A coefficient beat is written directly while the sequencer stays idle. A sample beat
// runs five taps through the one shared multiplier, one drain and one writeback per
// active section.
// o_ready is high only while the sequencer is idle.
// Reset clears coefficients, history and sets active_stages to 4.
// A waiting result stalls only the final step of the next sample.
module biquad_cascade_q14_top
    import bqc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_req_type,
    input  logic signed [DATA_W-1:0] i_sample_in,
    input  logic [1:0]               i_coef_stage,
    input  logic [2:0]               i_coef_slot,
    input  logic signed [DATA_W-1:0] i_coef_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_filt_out,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_wdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [2:0]               r_tap;
    logic [CNT_W-1:0]         r_stage;
    logic [2:0]               r_active;
    logic signed [DATA_W-1:0] r_x;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out;

    logic signed [DATA_W-1:0] r_coef [STAGES][SLOTS];
    logic signed [DATA_W-1:0] r_xh1  [STAGES];
    logic signed [DATA_W-1:0] r_xh2  [STAGES];
    logic signed [DATA_W-1:0] r_yh1  [STAGES];
    logic signed [DATA_W-1:0] r_yh2  [STAGES];

    logic                     in_acc;
    logic                     out_free;
    logic [7:0]               n_eff;
    logic [7:0]               stage_next;
    logic [STAGE_W-1:0]       sidx;
    logic                     coef_ok;
    t_mac_ctl                 mac_ctl;
    logic signed [DATA_W-1:0] mac_coef;
    logic signed [DATA_W-1:0] mac_op;
    logic signed [ACC_W-1:0]  acc;
    logic signed [DATA_W-1:0] y;

    assign o_ready    = (r_state == S_IDLE);
    assign in_acc     = i_valid && o_ready;
    assign out_free   = !r_out_valid || i_ready;
    assign n_eff      = (32'(r_active) > STAGES) ? 8'(STAGES) : 8'(r_active);
    assign stage_next = 8'(r_stage) + 8'd1;
    assign sidx       = r_stage[STAGE_W-1:0];
    assign coef_ok    = (32'(i_coef_stage) < STAGES) && (32'(i_coef_slot) < SLOTS);
    assign y          = sat16(acc[ACC_W-1:COEF_SHIFT]);

    always_comb begin
        case (r_tap)
            SLOT_B0: mac_op = r_x;
            SLOT_B1: mac_op = r_xh1[sidx];
            SLOT_B2: mac_op = r_xh2[sidx];
            SLOT_A1: mac_op = r_yh1[sidx];
            SLOT_A2: mac_op = r_yh2[sidx];
            default: mac_op = '0;
        endcase
        mac_coef = (32'(r_tap) < SLOTS) ? r_coef[sidx][r_tap] : '0;
    end

    always_comb begin
        mac_ctl = '0;
        case (r_state)
            S_MUL: begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.clr    = (r_tap == SLOT_B0);
                mac_ctl.acc_en = (r_tap != SLOT_B0);
                mac_ctl.sub    = (r_tap == SLOT_A2);
            end
            S_LAST: begin
                mac_ctl.acc_en = 1'b1;
                mac_ctl.sub    = 1'b1;
            end
            default: mac_ctl = '0;
        endcase
    end

    bqc_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_coef    (mac_coef),
        .i_operand (mac_op),
        .o_acc     (acc)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_req_type == REQ_SAMPLE) begin
                    n_state = (n_eff == 8'd0) ? S_DONE : S_MUL;
                end
            end
            S_MUL:  n_state = (r_tap == SLOT_A2) ? S_LAST : S_MUL;
            S_LAST: n_state = S_WB;
            S_WB:   n_state = (stage_next == n_eff) ? S_DONE : S_MUL;
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap       <= SLOT_B0;
            r_stage     <= '0;
            r_active    <= ACTIVE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    r_tap   <= SLOT_B0;
                    r_stage <= '0;
                end
                S_MUL:  r_tap <= r_tap + 3'd1;
                S_WB: begin
                    r_tap   <= SLOT_B0;
                    r_stage <= r_stage + CNT_W'(1);
                end
                default: r_tap <= r_tap;
            endcase
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_req_type == REQ_SAMPLE) begin
            r_x <= i_sample_in;
        end else if (r_state == S_WB) begin
            r_x <= y;
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                for (int k = 0; k < SLOTS; k++) begin
                    r_coef[s][k] <= '0;
                end
                r_xh1[s] <= '0;
                r_xh2[s] <= '0;
                r_yh1[s] <= '0;
                r_yh2[s] <= '0;
            end
        end else begin
            if (in_acc && i_req_type == REQ_COEF && coef_ok) begin
                r_coef[STAGE_W'(i_coef_stage)][i_coef_slot] <= i_coef_value;
            end
            if (r_state == S_WB) begin
                r_xh2[sidx] <= r_xh1[sidx];
                r_xh1[sidx] <= r_x;
                r_yh2[sidx] <= r_yh1[sidx];
                r_yh1[sidx] <= y;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filt_out = r_out;

endmodule

// ===== hw/rtl/bqc_mac.sv =====
module bqc_mac
    import bqc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [DATA_W-1:0] i_coef,
    input  logic signed [DATA_W-1:0] i_operand,
    output logic signed [ACC_W-1:0]  o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = ACC_W'(r_prod);

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.acc_en) begin
            n_acc = i_ctl.sub ? (r_acc - prod_ext) : (r_acc + prod_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_coef * i_operand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule
